// ----- rtl/core/kinematic_step_speed_clamp_defines.svh -----
// Assertion macros used by the checker file
`ifndef KINEMATIC_STEP_SPEED_CLAMP_DEFINES_SVH
`define KINEMATIC_STEP_SPEED_CLAMP_DEFINES_SVH
// Check that a condition implies a consequence in the next cycle
`define KSC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
// Check that a condition implies a consequence in the same cycle
`define KSC_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);
`endif

// ----- rtl/core/ksc_pkg.sv -----
// ----------------------------------------------------------------------------
// ksc_pkg
// Types and constants shared by the kinematic step block.
// ----------------------------------------------------------------------------
package ksc_pkg;

    localparam logic [1:0] OP_STEP     = 2'd0;
    localparam logic [1:0] OP_LOAD_VEL = 2'd1;
    localparam logic [1:0] OP_LOAD_ACC = 2'd2;
    localparam logic [1:0] OP_LOAD_POS = 2'd3;

    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_MAX_ACCEL = 1'b1;

    localparam int CfgWidth = 31;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        time_step;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } ksc_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               limited;
    } ksc_out_t;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_POS_UPD,
        CMD_VEL_UPD,
        CMD_SQ,
        CMD_SQRT,
        CMD_CMP,
        CMD_DIV,
        CMD_WRITE
    } ksc_cmd_e;

    typedef struct packed {
        ksc_cmd_e   cmd;
        logic [1:0] idx;
    } ksc_ctl_t;

    typedef struct packed {
        logic over;
        logic iter_done;
    } ksc_sts_t;

    // saturate a 41-bit sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sh000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -41'sh000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/ksc_datapath.sv -----
// ----------------------------------------------------------------------------
// ksc_datapath
// State vectors, dt products, magnitude by bit-serial root and scaling by
// restoring division, driven one step at a time by the controller.
// ----------------------------------------------------------------------------
module ksc_datapath import ksc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  ksc_ctl_t            ctl,
    input  ksc_in_t             in_word,
    input  logic [CfgWidth-1:0] max_speed,
    input  logic [CfgWidth-1:0] max_accel,
    output ksc_sts_t            sts,
    output ksc_out_t            out_word
);

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] acc_reg [3];
    logic signed [31:0] wv_reg  [3];
    logic [1:0]         op_reg;
    logic [15:0]        dt_reg;
    logic [CfgWidth-1:0] lim_reg;
    logic [65:0]        sumsq_reg;
    logic [65:0]        rem_reg;
    logic [32:0]        root_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        dvd_reg;
    logic [33:0]        drem_reg;
    logic               lim_flag_reg;

    logic signed [31:0] sel_v;
    logic [31:0]        abs_v;
    logic [63:0]        sq_v;
    logic signed [47:0] prod_v;
    logic signed [40:0] sum_v;
    logic [67:0]        trial_v;
    logic [67:0]        rem_sh_v;
    logic [34:0]        dtrial_v;
    logic [31:0]        q_v;
    logic signed [31:0] wr_v;

    function automatic logic signed [47:0] pos_mul(input logic signed [31:0] c);
        return 48'(c) * $signed({1'b0, dt_reg});
    endfunction

    always_comb begin
        sel_v  = wv_reg[ctl.idx];
        abs_v  = sel_v[31] ? 32'(-sel_v) : 32'(sel_v);
        sq_v   = {32'd0, abs_v} * {32'd0, abs_v};
        if (ctl.cmd == CMD_POS_UPD) begin
            prod_v = pos_mul(vel_reg[ctl.idx]);
            sum_v  = 41'(pos_reg[ctl.idx]) + 41'(prod_v >>> 8);
        end else begin
            prod_v = pos_mul(acc_reg[ctl.idx]);
            sum_v  = 41'(vel_reg[ctl.idx]) + 41'(prod_v >>> 8);
        end
        // one root bit: two radicand bits per iteration
        rem_sh_v = {rem_reg, sumsq_reg[65:64]};
        trial_v  = {33'd0, root_reg, 2'b01};
        dtrial_v = {drem_reg, dvd_reg[63]} - {2'b0, root_reg};
        q_v      = dvd_reg[31:0];
        // scaled component when clamping, else keep the word as it stands
        wr_v     = lim_flag_reg ? (sel_v[31] ? -$signed(q_v) : $signed(q_v)) : sel_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
            cnt_reg      <= '0;
            lim_flag_reg <= 1'b0;
        end else begin
            case (ctl.cmd)
                CMD_LATCH: begin
                    op_reg       <= in_word.operation;
                    dt_reg       <= in_word.time_step;
                    wv_reg[0]    <= in_word.vec_x;
                    wv_reg[1]    <= in_word.vec_y;
                    wv_reg[2]    <= in_word.vec_z;
                    lim_reg      <= (in_word.operation == OP_STEP) ? max_speed : max_accel;
                    sumsq_reg    <= '0;
                    lim_flag_reg <= 1'b0;
                end
                CMD_POS_UPD: begin
                    pos_reg[ctl.idx] <= sat32(sum_v);
                end
                CMD_VEL_UPD: begin
                    vel_reg[ctl.idx] <= sat32(sum_v);
                    wv_reg[ctl.idx]  <= sat32(sum_v);
                end
                CMD_SQ: begin
                    sumsq_reg <= sumsq_reg + 66'(sq_v);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                end
                CMD_SQRT: begin
                    if (rem_sh_v >= trial_v) begin
                        rem_reg  <= 66'(rem_sh_v - trial_v);
                        root_reg <= {root_reg[31:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh_v[65:0];
                        root_reg <= {root_reg[31:0], 1'b0};
                    end
                    sumsq_reg <= {sumsq_reg[63:0], 2'b00};
                    cnt_reg   <= cnt_reg + 6'd1;
                end
                CMD_CMP: begin
                    // load |c| * limit as dividend for this component
                    dvd_reg  <= {32'd0, abs_v} * {33'd0, lim_reg};
                    drem_reg <= '0;
                    cnt_reg  <= '0;
                    if (root_reg > {2'b0, lim_reg}) begin
                        lim_flag_reg <= 1'b1;
                    end
                end
                CMD_DIV: begin
                    if (!dtrial_v[34]) begin
                        drem_reg <= dtrial_v[33:0];
                        dvd_reg  <= {dvd_reg[62:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[32:0], dvd_reg[63]};
                        dvd_reg  <= {dvd_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                CMD_WRITE: begin
                    // quotient does not exceed the limit, so 31 bits suffice
                    wv_reg[ctl.idx] <= wr_v;
                end
                default: begin
                end
            endcase
            // commit the working vector on the last component
            if (ctl.cmd == CMD_WRITE && ctl.idx == 2'd2) begin
                for (int i = 0; i < 3; i++) begin
                    if (op_reg == OP_STEP || op_reg == OP_LOAD_VEL) begin
                        vel_reg[i] <= (i == 2) ? wr_v : wv_reg[i];
                    end else if (op_reg == OP_LOAD_ACC) begin
                        acc_reg[i] <= (i == 2) ? wr_v : wv_reg[i];
                    end else begin
                        pos_reg[i] <= (i == 2) ? wr_v : wv_reg[i];
                    end
                end
            end
        end
    end

    assign sts.over      = root_reg > {2'b0, lim_reg};
    assign sts.iter_done = (ctl.cmd == CMD_SQRT) ? (cnt_reg == 6'd32) : (cnt_reg == 6'd63);

    assign out_word.pos_x   = pos_reg[0];
    assign out_word.pos_y   = pos_reg[1];
    assign out_word.pos_z   = pos_reg[2];
    assign out_word.vel_x   = vel_reg[0];
    assign out_word.vel_y   = vel_reg[1];
    assign out_word.vel_z   = vel_reg[2];
    assign out_word.limited = lim_flag_reg;

endmodule

// ----- rtl/core/ksc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ksc_ctrl
// Sequencer: latch word, update (step only), magnitude and scale (step and acceleration load), commit, present result.
// ----------------------------------------------------------------------------
module ksc_ctrl import ksc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  logic [1:0] operation,
    input  ksc_sts_t sts,
    output ksc_ctl_t ctl
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_POS, ST_VEL, ST_SQ, ST_SQRT, ST_CMP, ST_DIV, ST_WR, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] idx_reg;
    logic       clamp_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        ctl.idx = idx_reg;
        case (state_reg)
            ST_IDLE: ctl.cmd = s_valid ? CMD_LATCH : CMD_NONE;
            ST_POS:  ctl.cmd = CMD_POS_UPD;
            ST_VEL:  ctl.cmd = CMD_VEL_UPD;
            ST_SQ:   ctl.cmd = CMD_SQ;
            ST_SQRT: ctl.cmd = CMD_SQRT;
            ST_CMP:  ctl.cmd = CMD_CMP;
            ST_DIV:  ctl.cmd = clamp_reg ? CMD_DIV : CMD_NONE;
            ST_WR:   ctl.cmd = CMD_WRITE;
            default: ctl.cmd = CMD_NONE;
        endcase
    end

    // advance the sequence
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            clamp_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        idx_reg <= '0;
                        if (operation == OP_STEP) begin
                            state_reg <= ST_POS;
                        end else if (operation == OP_LOAD_ACC) begin
                            state_reg <= ST_SQ;
                        end else begin
                            state_reg <= ST_WR;
                            idx_reg   <= 2'd2;
                        end
                    end
                end
                ST_POS: begin
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    if (idx_reg == 2'd2) state_reg <= ST_VEL;
                end
                ST_VEL: begin
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    if (idx_reg == 2'd2) state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    if (idx_reg == 2'd2) state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sts.iter_done) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    clamp_reg <= sts.over;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (!clamp_reg || sts.iter_done) begin
                        state_reg <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (idx_reg == 2'd2) begin
                        state_reg <= ST_OUT;
                        clamp_reg <= 1'b0;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_CMP;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/kinematic_step_speed_clamp.sv -----
// A step updates position, then velocity, then forms the magnitude by a bit-serial
// root and makes a compare, divide and write pass per component; the divide runs only
// when the clamp scales. An acceleration load skips the updates; a velocity or position
// load only writes. Handshake: one word at a time; the next word can be accepted in the
// cycle after the result leaves. Reset: synchronous active-low aresetn clears the state
// vectors and sets both limits to their maximum.
// ----------------------------------------------------------------------------
// kinematic_step_speed_clamp
// Euler integrator with speed and acceleration clamping, Q16.16.
// ----------------------------------------------------------------------------
module kinematic_step_speed_clamp import ksc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ksc_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ksc_out_t            m_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CfgWidth-1:0] cfg_wdata
);

    logic [CfgWidth-1:0] max_speed_reg;
    logic [CfgWidth-1:0] max_accel_reg;
    ksc_ctl_t            ctl;
    ksc_sts_t            sts;

    // hold the limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= '1;
            max_accel_reg <= '1;
        end else if (cfg_we) begin
            if (cfg_index == REG_MAX_SPEED) max_speed_reg <= cfg_wdata;
            if (cfg_index == REG_MAX_ACCEL) max_accel_reg <= cfg_wdata;
        end
    end

    ksc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .operation (s_data.operation),
        .sts       (sts),
        .ctl       (ctl)
    );

    ksc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .in_word   (s_data),
        .max_speed (max_speed_reg),
        .max_accel (max_accel_reg),
        .sts       (sts),
        .out_word  (m_data)
    );

endmodule

// ----- rtl/core/ksc_checker.sv -----
// ----------------------------------------------------------------------------
// ksc_checker
// Port-level checks of the kinematic step block.
// ----------------------------------------------------------------------------
`include "kinematic_step_speed_clamp_defines.svh"
module ksc_checker import ksc_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input ksc_out_t m_data
);

    `KSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")
    `KSC_ASSERT_SAME(a_one_word, aclk, aresetn, m_valid, !s_ready, "input taken while a result waits")
    `KSC_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "second word taken while busy")

endmodule

bind kinematic_step_speed_clamp ksc_checker u_ksc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the kinematic step block: a local motion model predicts every result
// word, and the run walks through several clamp limits and handshake stalls.
// ----------------------------------------------------------------------------
module tb;
    import ksc_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 300;

    typedef longint vec3_t [3];

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ksc_in_t             s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ksc_out_t            m_data;
    logic                cfg_we = 1'b0;
    logic                cfg_index = REG_MAX_SPEED;
    logic [CfgWidth-1:0] cfg_wdata = '0;

    // words waiting to be sent and results still owed
    ksc_in_t  pending_words[$];
    ksc_out_t owed_results[$];

    // model state and limit shadows
    vec3_t pos_s, vel_s, acc_s;
    longint unsigned speed_lim = 64'h7FFF_FFFF;
    longint unsigned accel_lim = 64'h7FFF_FFFF;

    int idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int n_words = 0, n_steps = 0, n_clamped = 0;
    bit s_took = 1'b0;

    kinematic_step_speed_clamp dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // c (Q16.16) times dt (Q8.8), floor back to Q16.16
    function automatic longint scale_by_dt(longint c, longint dt);
        return (c * dt) >>> 8;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // pull v onto the limit when its magnitude exceeds it, truncating to zero
    function automatic bit clamp_onto(inout vec3_t v, input longint unsigned lim);
        longint unsigned sq = 0;
        longint unsigned mag, a, q;
        for (int i = 0; i < 3; i++) begin
            a = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            sq += a * a;
        end
        mag = floor_root(sq);
        if (mag <= lim) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            a = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            q = a * lim / mag;
            v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // apply one word to the motion state and form the result it owes
    function automatic ksc_out_t advance_motion(ksc_in_t w);
        ksc_out_t r;
        vec3_t v;
        bit lim = 1'b0;
        v[0] = longint'(w.vec_x);
        v[1] = longint'(w.vec_y);
        v[2] = longint'(w.vec_z);
        case (w.operation)
            OP_STEP: begin
                for (int i = 0; i < 3; i++)
                    pos_s[i] = clip32(pos_s[i] + scale_by_dt(vel_s[i], w.time_step));
                for (int i = 0; i < 3; i++)
                    vel_s[i] = clip32(vel_s[i] + scale_by_dt(acc_s[i], w.time_step));
                lim = clamp_onto(vel_s, speed_lim);
            end
            OP_LOAD_VEL: vel_s = v;
            OP_LOAD_ACC: begin
                lim = clamp_onto(v, accel_lim);
                acc_s = v;
            end
            default: pos_s = v;
        endcase
        r.pos_x = pos_s[0][31:0];
        r.pos_y = pos_s[1][31:0];
        r.pos_z = pos_s[2][31:0];
        r.vel_x = vel_s[0][31:0];
        r.vel_y = vel_s[1][31:0];
        r.vel_z = vel_s[2][31:0];
        r.limited = lim;
        return r;
    endfunction

    function automatic void check_field(string nm, longint e, longint a);
        if (e != a) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, nm, e, a);
            errors++;
        end
    endfunction

    // driver: advance the input word and the result stall at the falling edge
    always @(negedge aclk) begin
        logic    nv;
        ksc_in_t nd;
        nv = s_valid;
        nd = s_data;
        if (aresetn) begin
            if (s_valid && s_took) nv = 1'b0;
            if (!nv && pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                nv = 1'b1;
                nd = pending_words.pop_front();
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
        s_valid <= nv;
        s_data  <= nd;
    end

    // monitor: predict on input acceptance, check each result word
    always @(posedge aclk) begin
        ksc_out_t e;
        bit moved;
        moved = 1'b0;
        if (aresetn) begin
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                moved = 1'b1;
                n_words++;
                if (s_data.operation == OP_STEP) n_steps++;
                owed_results.push_back(advance_motion(s_data));
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_data);
                    errors++;
                end else begin
                    e = owed_results.pop_front();
                    if (m_data.limited) n_clamped++;
                    check_field("pos_x", e.pos_x, m_data.pos_x);
                    check_field("pos_y", e.pos_y, m_data.pos_y);
                    check_field("pos_z", e.pos_z, m_data.pos_z);
                    check_field("vel_x", e.vel_x, m_data.vel_x);
                    check_field("vel_y", e.vel_y, m_data.vel_y);
                    check_field("vel_z", e.vel_z, m_data.vel_z);
                    check_field("limited", e.limited, m_data.limited);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("%0t: watchdog, %0d results owed", $time, owed_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic ksc_in_t make_word(logic [1:0] op, logic [15:0] dt,
                                          int x, int y, int z);
        ksc_in_t w;
        w.operation = op;
        w.time_step = dt;
        w.vec_x = x;
        w.vec_y = y;
        w.vec_z = z;
        return w;
    endfunction

    // random component: full range sometimes, mostly scaled down
    function automatic int rand_comp();
        int v;
        v = int'($urandom);
        if ($urandom_range(3) != 0) v = v >>> $urandom_range(20, 6);
        return v;
    endfunction

    function automatic logic [15:0] rand_dt();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(1023));
    endfunction

    task automatic write_limit(logic idx, logic [CfgWidth-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_MAX_SPEED) speed_lim = val;
        else accel_lim = val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // hold the sender until every owed result is back, then let the block settle
    task automatic drain();
        wait (pending_words.size() == 0 && !s_valid && owed_results.size() == 0);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_words.push_back(make_word(2'($urandom), rand_dt(),
                                              rand_comp(), rand_comp(), rand_comp()));
    endtask

    initial begin
        logic [CfgWidth-1:0] spd [5];
        logic [CfgWidth-1:0] acc [5];
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every operation, saturation and clamps
        pending_words.push_back(make_word(OP_STEP, 16'hFFFF, 0, 0, 0));
        pending_words.push_back(make_word(OP_LOAD_POS, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        pending_words.push_back(make_word(OP_LOAD_VEL, 0, 32'h7FFF_FFFF, 32'h8000_0000, -1));
        pending_words.push_back(make_word(OP_STEP, 16'hFFFF, 0, 0, 0));
        pending_words.push_back(make_word(OP_STEP, 16'h0000, 0, 0, 0));
        pending_words.push_back(make_word(OP_LOAD_ACC, 0, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000));
        pending_words.push_back(make_word(OP_STEP, 16'h0100, 0, 0, 0));
        pending_words.push_back(make_word(OP_LOAD_ACC, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF));
        pending_words.push_back(make_word(OP_STEP, 16'h8000, 0, 0, 0));
        pending_words.push_back(make_word(OP_LOAD_POS, 0, 0, -1, 1));
        pending_words.push_back(make_word(OP_LOAD_VEL, 0, 32'h0001_0000, -32'h0002_0000,
                                          32'h0000_8000));
        pending_words.push_back(make_word(OP_LOAD_ACC, 0, -32'h0001_0000, 0, 32'h0003_0000));
        pending_words.push_back(make_word(OP_STEP, 16'h0001, 0, 0, 0));
        pending_words.push_back(make_word(OP_STEP, 16'h0180, 32'hFFFF_FFFF, 1, 2));
        drain();

        // zero limits: any nonzero acceleration load or stepped velocity collapses
        write_limit(REG_MAX_SPEED, '0);
        write_limit(REG_MAX_ACCEL, '0);
        pending_words.push_back(make_word(OP_LOAD_ACC, 0, 5, -7, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(OP_LOAD_ACC, 0, 0, 0, 0));
        pending_words.push_back(make_word(OP_LOAD_VEL, 0, 32'h0004_0000, 3, -9));
        pending_words.push_back(make_word(OP_STEP, 16'h0000, 0, 0, 0));
        pending_words.push_back(make_word(OP_STEP, 16'h0100, 0, 0, 0));
        drain();

        spd = '{31'h7FFF_FFFF, 31'h0, 31'h000A_0000, 31'h0001_0000, 31'h7FFF_FFFF};
        acc = '{31'h7FFF_FFFF, 31'h0, 31'h0002_0000, 31'h7FFF_FFFF, 31'h0000_8000};
        spd[4] = 31'($urandom);
        for (int ph = 0; ph < 8; ph++) begin
            write_limit(REG_MAX_SPEED, spd[ph % 5]);
            write_limit(REG_MAX_ACCEL, acc[(ph + 2) % 5]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            queue_random(228);
            drain();
        end

        $display("Covered %0d words (%0d steps), %0d clamped results, 10 limit settings.",
                 n_words, n_steps, n_clamped);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ksc_pkg.sv
rtl/core/ksc_datapath.sv
rtl/core/ksc_ctrl.sv
rtl/core/kinematic_step_speed_clamp.sv
rtl/core/ksc_checker.sv
tb/tb.sv
